@@ hw/rtl/gasn_pkg.sv @@
package gasn_pkg;

	// Default grid and open-list sizes.
	localparam int GRID_WIDTH_DEF  = 32;
	localparam int GRID_HEIGHT_DEF = 32;
	localparam int OPEN_DEPTH_DEF  = 4096;

	// Fixed field widths.
	localparam int COORD_W   = 5;
	localparam int G_W       = 16;
	localparam int FRAC_BITS = 8;
	localparam int F_W       = G_W + FRAC_BITS + 1;

	// Move codes, also used as the parent direction of a cell.
	typedef logic [2:0] move_t;
	localparam move_t MOVE_YP   = 3'd0;
	localparam move_t MOVE_XM   = 3'd1;
	localparam move_t MOVE_XP   = 3'd2;
	localparam move_t MOVE_YM   = 3'd3;
	localparam move_t MOVE_NONE = 3'd4;

	typedef struct packed {
		logic [COORD_W-1:0] block_x;
		logic [COORD_W-1:0] block_y;
		logic [COORD_W-1:0] free_x;
		logic [COORD_W-1:0] free_y;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] goal_x;
		logic [COORD_W-1:0] goal_y;
	} cmd_t;

	typedef struct packed {
		logic [1:0] direction;
		logic       found;
	} res_t;

	// Per-cell search record.
	typedef struct packed {
		logic           learned;
		move_t          parent;
		logic [G_W-1:0] cost;
		logic [F_W-1:0] f;
	} cell_rec_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_BLK, S_FREE, S_INIT, S_HS, S_HSW,
		S_POP, S_POPD, S_CURD, S_NB, S_NBD, S_NBH,
		S_SST, S_SI, S_SID, S_SIF, S_SJ, S_SJD, S_SJF, S_SW,
		S_DP, S_DPD, S_DPF, S_DM, S_MV, S_MVD, S_CHK,
		S_BT, S_BTD, S_OUT
	} state_t;

endpackage

@@ hw/rtl/grid_astar_next_move.sv @@
// Grid A* next-move engine for a 4-connected grid. Each command beat first marks one cell
// of the stored obstacle map blocked and then frees another (coordinates outside the grid
// are ignored, and a cell named in both ends up free), then runs an A* search from start to
// goal over the play area, columns 1..GRID_WIDTH-1 and rows 3..GRID_HEIGHT-1, with unit step
// cost and a Euclidean heuristic in unsigned Q6.8 (at the default grid). The result beat
// carries the first move from the start (0 y plus, 1 x minus, 2 x plus, 3 y minus) and a
// found flag; direction is 0 when found is 0, and found is 0 when start equals goal or
// either lies outside the play area. After reset the obstacle map is cleared one cell per
// cycle, all 2^(XW+YW) cells (1024 at the default 32 by 32 grid, XW and YW being the bit
// widths of the column and row), and no command is taken meanwhile. A command first
// rewrites every per-cell record, then for every expanded cell tries each neighbor
// position, reads each neighbor inside the play area and runs the bit-serial square root
// for each relaxed neighbor, then sorts the open list with a stable insertion sort, drops
// the learned heads and shifts the remaining entries down, and finally walks the path back
// from the goal. The record memory and the open-list memory, each with one write port and
// one read port, and the one shared square-root unit set the pace of a command.
// A finished result waits in an output register, so a new command is taken while it sits
// stalled.
module grid_astar_next_move #(
	parameter int GRID_WIDTH  = gasn_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = gasn_pkg::GRID_HEIGHT_DEF,
	parameter int OPEN_DEPTH  = gasn_pkg::OPEN_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  gasn_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output gasn_pkg::res_t res
);
	import gasn_pkg::*;

	// Cells are addressed as {row, column}, so no multiply or divide is needed to move
	// between a cell address and its coordinates.
	localparam int XW     = $clog2(GRID_WIDTH);
	localparam int YW     = $clog2(GRID_HEIGHT);
	localparam int AW     = XW + YW;
	localparam int CW     = (XW > YW) ? XW : YW;
	localparam int RW     = CW + FRAC_BITS + 1;
	localparam int LW     = $clog2(OPEN_DEPTH);
	localparam int CNTW   = $clog2(OPEN_DEPTH + 1);
	localparam int CELL_N = 1 << AW;

	state_t state_q, state_d;

	// Stored maps and the open list.
	logic      obs_mem  [CELL_N];
	cell_rec_t cell_mem [CELL_N];
	logic [AW-1:0] list_mem [OPEN_DEPTH];

	logic          obs_we, obs_wd, obs_rd_q;
	logic [AW-1:0] obs_wa, obs_ra;
	logic          cell_we;
	logic [AW-1:0] cell_wa, cell_ra;
	cell_rec_t     cell_wd, cell_rd_q;
	logic          list_we;
	logic [LW-1:0] list_wa, list_ra;
	logic [AW-1:0] list_wd, list_rd_q;

	// Heuristic unit.
	logic          heur_start, heur_done;
	logic [CW-1:0] heur_x, heur_y;
	logic [RW-1:0] heur_h;

	// Sequencer counters.
	logic [AW-1:0]   ctr_q;
	logic [CNTW-1:0] count_q, i_q, j_q, p_q, q_q;
	logic [1:0]      k_q;
	logic            res_valid_q;

	// Working registers.
	cmd_t           cmd_q;
	logic [AW-1:0]  cur_q, nb_q, e_q, a_q, bt_q;
	logic [G_W-1:0] cur_cost_q;
	logic           nb_learned_q;
	move_t          mv_q;
	logic [G_W:0]   cand_q;
	logic [F_W-1:0] fe_q;
	res_t           rslt_q, res_q;

	// Decoded command.
	logic [XW-1:0] sx, gx;
	logic [YW-1:0] sy, gy;
	logic [AW-1:0] s_addr, g_addr, blk_addr, free_addr;
	logic          blk_in, free_in, play_ok;

	// Neighbor, relaxation and path-walk helpers.
	logic [XW-1:0]   curx, btx;
	logic [YW-1:0]   cury, bty;
	logic            nb_ok, push_c, relax_c, sort_gt, slot_free;
	logic [AW-1:0]   nb_c, par_c;
	move_t           mv_c;
	logic [G_W:0]    cand_c;
	logic [F_W-1:0]  f_relax;
	logic [CNTW-1:0] jm1, qp, rest;
	cell_rec_t       init_rec;

	always_comb begin
		sx        = XW'(cmd_q.start_x);
		sy        = YW'(cmd_q.start_y);
		gx        = XW'(cmd_q.goal_x);
		gy        = YW'(cmd_q.goal_y);
		s_addr    = {sy, sx};
		g_addr    = {gy, gx};
		blk_addr  = {YW'(cmd_q.block_y), XW'(cmd_q.block_x)};
		free_addr = {YW'(cmd_q.free_y), XW'(cmd_q.free_x)};
		blk_in    = (32'(cmd_q.block_x) < GRID_WIDTH) && (32'(cmd_q.block_y) < GRID_HEIGHT);
		free_in   = (32'(cmd_q.free_x) < GRID_WIDTH) && (32'(cmd_q.free_y) < GRID_HEIGHT);
		play_ok   = (cmd_q.start_x != '0) && (32'(cmd_q.start_x) < GRID_WIDTH) &&
			(32'(cmd_q.start_y) >= 32'd3) && (32'(cmd_q.start_y) < GRID_HEIGHT) &&
			(cmd_q.goal_x != '0) && (32'(cmd_q.goal_x) < GRID_WIDTH) &&
			(32'(cmd_q.goal_y) >= 32'd3) && (32'(cmd_q.goal_y) < GRID_HEIGHT);

		curx = cur_q[XW-1:0];
		cury = cur_q[AW-1:XW];
		// Neighbors are tried y minus, y plus, x minus, x plus; the move code is the
		// step from the current cell into the neighbor.
		unique case (k_q)
			2'd0: begin
				nb_ok = (cury > YW'(3));
				nb_c  = {cury - YW'(1), curx};
				mv_c  = MOVE_YM;
			end
			2'd1: begin
				nb_ok = (cury != YW'(GRID_HEIGHT - 1));
				nb_c  = {cury + YW'(1), curx};
				mv_c  = MOVE_YP;
			end
			2'd2: begin
				nb_ok = (curx > XW'(1));
				nb_c  = {cury, curx - XW'(1)};
				mv_c  = MOVE_XM;
			end
			default: begin
				nb_ok = (curx != XW'(GRID_WIDTH - 1));
				nb_c  = {cury, curx + XW'(1)};
				mv_c  = MOVE_XP;
			end
		endcase

		// A blocked or learned neighbor is not queued, but is still relaxed.
		push_c  = !cell_rd_q.learned && !obs_rd_q && (count_q < CNTW'(OPEN_DEPTH));
		cand_c  = {1'b0, cur_cost_q} + (G_W + 1)'(1);
		relax_c = (cand_c < {1'b0, cell_rd_q.cost});
		f_relax = F_W'({cand_q[G_W-1:0], {FRAC_BITS{1'b0}}}) + F_W'(heur_h);
		sort_gt = (cell_rd_q.f > fe_q);

		jm1  = j_q - CNTW'(1);
		qp   = q_q + p_q;
		rest = count_q - p_q;

		// Walking back, the parent lies opposite to the recorded move.
		btx = bt_q[XW-1:0];
		bty = bt_q[AW-1:XW];
		unique case (cell_rd_q.parent)
			MOVE_YP: par_c = {bty - YW'(1), btx};
			MOVE_XM: par_c = {bty, btx + XW'(1)};
			MOVE_XP: par_c = {bty, btx - XW'(1)};
			MOVE_YM: par_c = {bty + YW'(1), btx};
			default: par_c = bt_q;
		endcase

		slot_free = !res_valid_q || !res_stall;

		init_rec.learned = 1'b0;
		init_rec.parent  = MOVE_NONE;
		init_rec.cost    = '1;
		init_rec.f       = '1;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:  if (ctr_q == {AW{1'b1}}) state_d = S_IDLE;
			S_IDLE: if (cmd_valid) state_d = S_BLK;
			S_BLK:  state_d = S_FREE;
			S_FREE: state_d = play_ok ? S_INIT : S_OUT;
			S_INIT: if (ctr_q == {AW{1'b1}}) state_d = S_HS;
			S_HS:   state_d = S_HSW;
			S_HSW:  if (heur_done) state_d = (s_addr == g_addr) ? S_BT : S_POP;
			S_POP:  state_d = S_POPD;
			S_POPD: state_d = S_CURD;
			S_CURD: state_d = S_NB;
			S_NB: begin
				if (nb_ok) begin
					state_d = S_NBD;
				end else if (k_q == 2'd3) begin
					state_d = S_SST;
				end
			end
			S_NBD: begin
				if (relax_c) begin
					state_d = S_NBH;
				end else begin
					state_d = (k_q == 2'd3) ? S_SST : S_NB;
				end
			end
			S_NBH:  if (heur_done) state_d = (k_q == 2'd3) ? S_SST : S_NB;
			S_SST:  state_d = (count_q <= CNTW'(1)) ? S_DP : S_SI;
			S_SI:   state_d = S_SID;
			S_SID:  state_d = S_SIF;
			S_SIF:  state_d = S_SJ;
			S_SJ:   state_d = (j_q == '0) ? S_SW : S_SJD;
			S_SJD:  state_d = S_SJF;
			S_SJF:  state_d = sort_gt ? S_SJ : S_SW;
			S_SW:   state_d = (i_q == count_q - CNTW'(1)) ? S_DP : S_SI;
			S_DP:   state_d = (p_q == count_q) ? S_DM : S_DPD;
			S_DPD:  state_d = S_DPF;
			S_DPF:  state_d = cell_rd_q.learned ? S_DP : S_DM;
			S_DM:   state_d = (p_q == '0) ? S_CHK : S_MV;
			S_MV:   state_d = (q_q == rest) ? S_CHK : S_MVD;
			S_MVD:  state_d = S_MV;
			S_CHK:  state_d = ((count_q == '0) || (cur_q == g_addr)) ? S_BT : S_POP;
			S_BT:   state_d = S_BTD;
			S_BTD: begin
				if ((cell_rd_q.parent == MOVE_NONE) || (par_c == s_addr)) begin
					state_d = S_OUT;
				end else begin
					state_d = S_BT;
				end
			end
			S_OUT:  if (slot_free) state_d = S_IDLE;
			default: state_d = S_CLR;
		endcase
	end

	// Memory ports and unit control.
	always_comb begin
		obs_we     = 1'b0;
		obs_wa     = ctr_q;
		obs_wd     = 1'b0;
		obs_ra     = nb_c;
		cell_we    = 1'b0;
		cell_wa    = ctr_q;
		cell_wd    = init_rec;
		cell_ra    = list_rd_q;
		list_we    = 1'b0;
		list_wa    = '0;
		list_wd    = nb_q;
		list_ra    = '0;
		heur_start = 1'b0;
		heur_x     = CW'(nb_q[XW-1:0]);
		heur_y     = CW'(nb_q[AW-1:XW]);
		unique case (state_q)
			S_CLR: obs_we = 1'b1;
			S_BLK: begin
				obs_we = blk_in;
				obs_wa = blk_addr;
				obs_wd = 1'b1;
			end
			S_FREE: begin
				obs_we = free_in;
				obs_wa = free_addr;
			end
			S_INIT: cell_we = 1'b1;
			S_HS: begin
				heur_start = 1'b1;
				heur_x     = CW'(sx);
				heur_y     = CW'(sy);
			end
			S_HSW: begin
				cell_we         = heur_done;
				cell_wa         = s_addr;
				cell_wd.learned = 1'b0;
				cell_wd.parent  = MOVE_NONE;
				cell_wd.cost    = '0;
				cell_wd.f       = F_W'(heur_h);
				list_we         = heur_done;
				list_wd         = s_addr;
			end
			S_CURD: begin
				cell_we         = 1'b1;
				cell_wa         = cur_q;
				cell_wd         = cell_rd_q;
				cell_wd.learned = 1'b1;
			end
			S_NB: cell_ra = nb_c;
			S_NBD: begin
				list_we    = push_c;
				list_wa    = count_q[LW-1:0];
				heur_start = relax_c;
			end
			S_NBH: begin
				cell_we         = heur_done;
				cell_wa         = nb_q;
				cell_wd.learned = nb_learned_q;
				cell_wd.parent  = mv_q;
				cell_wd.cost    = cand_q[G_W-1:0];
				cell_wd.f       = f_relax;
			end
			S_SI: list_ra = i_q[LW-1:0];
			S_SJ: list_ra = jm1[LW-1:0];
			S_SJF: begin
				list_we = sort_gt;
				list_wa = j_q[LW-1:0];
				list_wd = a_q;
			end
			S_SW: begin
				list_we = 1'b1;
				list_wa = j_q[LW-1:0];
				list_wd = e_q;
			end
			S_DP: list_ra = p_q[LW-1:0];
			S_MV: list_ra = qp[LW-1:0];
			S_MVD: begin
				list_we = 1'b1;
				list_wa = q_q[LW-1:0];
				list_wd = list_rd_q;
			end
			S_BT: cell_ra = bt_q;
			default: begin
			end
		endcase
	end

	// Sequencer control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ctr_q       <= '0;
			count_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			p_q         <= '0;
			q_q         <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new result may replace one that leaves in the same cycle.
			if ((state_q == S_OUT) && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR:  ctr_q <= ctr_q + AW'(1);
				S_FREE: ctr_q <= '0;
				S_INIT: ctr_q <= ctr_q + AW'(1);
				S_HSW:  if (heur_done) count_q <= CNTW'(1);
				S_CURD: k_q <= '0;
				S_NB:   if (!nb_ok && (k_q != 2'd3)) k_q <= k_q + 2'd1;
				S_NBD: begin
					if (push_c) begin
						count_q <= count_q + CNTW'(1);
					end
					if (!relax_c && (k_q != 2'd3)) begin
						k_q <= k_q + 2'd1;
					end
				end
				S_NBH:  if (heur_done && (k_q != 2'd3)) k_q <= k_q + 2'd1;
				S_SST: begin
					i_q <= CNTW'(1);
					p_q <= '0;
				end
				S_SIF:  j_q <= i_q;
				S_SJF:  if (sort_gt) j_q <= jm1;
				S_SW:   i_q <= i_q + CNTW'(1);
				S_DPF:  if (cell_rd_q.learned) p_q <= p_q + CNTW'(1);
				S_DM:   q_q <= '0;
				S_MV:   if (q_q == rest) count_q <= rest;
				S_MVD:  q_q <= q_q + CNTW'(1);
				default: begin
				end
			endcase
		end
	end

	// Working data registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (cmd_valid) cmd_q <= cmd;
			S_FREE: rslt_q <= '0;
			S_HSW: begin
				cur_q <= s_addr;
				bt_q  <= g_addr;
			end
			S_POPD: cur_q <= list_rd_q;
			S_CURD: cur_cost_q <= cell_rd_q.cost;
			S_NB: begin
				nb_q <= nb_c;
				mv_q <= mv_c;
			end
			S_NBD: begin
				nb_learned_q <= cell_rd_q.learned;
				cand_q       <= cand_c;
			end
			S_SID:  e_q <= list_rd_q;
			S_SIF:  fe_q <= cell_rd_q.f;
			S_SJD:  a_q <= list_rd_q;
			S_CHK:  bt_q <= g_addr;
			S_BTD: begin
				bt_q <= par_c;
				if (cell_rd_q.parent == MOVE_NONE) begin
					rslt_q <= '0;
				end else begin
					rslt_q.direction <= cell_rd_q.parent[1:0];
					rslt_q.found     <= 1'b1;
				end
			end
			S_OUT:  if (slot_free) res_q <= rslt_q;
			default: begin
			end
		endcase
	end

	// Memories, each with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (obs_we) begin
			obs_mem[obs_wa] <= obs_wd;
		end
		obs_rd_q <= obs_mem[obs_ra];
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_wa] <= cell_wd;
		end
		cell_rd_q <= cell_mem[cell_ra];
	end

	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_wa] <= list_wd;
		end
		list_rd_q <= list_mem[list_ra];
	end

	gasn_heur #(
		.CW(CW)
	) u_heur (
		.clk   (clk),
		.arst_n(arst_n),
		.start (heur_start),
		.x     (heur_x),
		.y     (heur_y),
		.gx    (CW'(gx)),
		.gy    (CW'(gy)),
		.done  (heur_done),
		.h     (heur_h)
	);

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	a_heur_owner: assert property (@(posedge clk) disable iff (!arst_n)
		heur_done |-> (state_q == S_HSW || state_q == S_NBH))
		else $error("heuristic result with no request pending");

	a_cmd_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (state_q == S_BLK))
		else $error("accepted command did not start the map update");

	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result beat raised outside the result hand-off");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(OPEN_DEPTH))
		else $error("open list count beyond its depth");
`endif

endmodule

@@ hw/rtl/gasn_heur.sv @@
module gasn_heur #(
	parameter int CW = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [CW-1:0]                   x,
	input  logic [CW-1:0]                   y,
	input  logic [CW-1:0]                   gx,
	input  logic [CW-1:0]                   gy,
	output logic                            done,
	output logic [CW+gasn_pkg::FRAC_BITS:0] h
);
	import gasn_pkg::*;

	localparam int RW    = CW + FRAC_BITS + 1;
	localparam int VW    = 2 * RW;
	localparam int REM_W = RW + 3;
	localparam int CNT_W = $clog2(RW + 1);

	logic [CW-1:0]    dx, dy;
	logic [2*CW-1:0]  sqx, sqy;
	logic [2*CW:0]    d2;
	logic [VW-1:0]    v_next;
	logic [REM_W-1:0] rem_sh, trial;
	logic             ge;

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW-1:0]    v_q;
	logic [REM_W-1:0] rem_q;
	logic [RW-1:0]    root_q;

	always_comb begin
		dx     = (x > gx) ? x - gx : gx - x;
		dy     = (y > gy) ? y - gy : gy - y;
		sqx    = dx * dx;
		sqy    = dy * dy;
		d2     = {1'b0, sqx} + {1'b0, sqy};
		v_next = VW'({d2, {(2 * FRAC_BITS){1'b0}}});
		// One root bit per cycle, two radicand bits brought down each time.
		rem_sh = {rem_q[REM_W-3:0], v_q[VW-1:VW-2]};
		trial  = REM_W'({root_q, 2'b01});
		ge     = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= v_next;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[VW-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign h    = root_q;

endmodule

@@ bench/grid_astar_next_move_tb.sv @@
// Self-checking bench for the grid A* next-move engine. Every accepted command beat is
// replayed through a behavioral copy of the engine held in the scoreboard. That copy keeps its
// own obstacle map and works out the expected first move and found flag. Result beats are
// checked in order against those predictions.
module grid_astar_next_move_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gasn_pkg::*;

	localparam int GW    = 32;
	localparam int GH    = 32;
	localparam int CELLS = GW * GH;
	localparam int ODEP  = 4096;
	localparam int PLAY_Y0 = 3;

	// A single search can expand the whole grid with a long open list, so this limit is
	// set far above the slowest command that a correct engine could take.
	localparam int IDLE_LIMIT = 200_000_000;
	localparam int HOLD_CYCLES = 400_000;
	localparam int N_RANDOM = 100;

	// The scoreboard holds the predicted engine state and the ring of expected moves.
	class move_scoreboard;
		bit          blocked[CELLS];
		logic [15:0] cost[CELLS];
		bit   [31:0] fest[CELLS];
		move_t       parent[CELLS];
		bit          learned[CELLS];
		bit   [9:0]  open[ODEP];
		int unsigned open_n;
		res_t        due_mem[256];
		int unsigned due_wr, due_rd;
		int          errors;
		int          n_found, n_missing;

		function new();
			foreach (blocked[i]) blocked[i] = 0;
			due_wr = 0;
			due_rd = 0;
			errors = 0;
			n_found = 0;
			n_missing = 0;
		endfunction

		function int unsigned pending();
			return due_wr - due_rd;
		endfunction

		static function bit [31:0] dist_q8(int x, int y, int gx, int gy);
			longint unsigned v, r, b;
			int dx, dy;
			dx = (x > gx) ? x - gx : gx - x;
			dy = (y > gy) ? y - gy : gy - y;
			v = longint'(dx * dx + dy * dy) << 16;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r[31:0];
		endfunction

		static function bit in_play(int x, int y);
			return x >= 1 && x < GW && y >= PLAY_Y0 && y < GH;
		endfunction

		function res_t search_move(cmd_t c);
			res_t r;
			int s, g, cur, cx, cy, nb, nx, ny, p, j, walk, par;
			int unsigned cand;
			bit [9:0] e;
			move_t mv;
			r = '0;
			// Coordinates are 5 bits wide, so every one lies inside the 32 by 32 grid.
			blocked[c.block_y * GW + c.block_x] = 1;
			blocked[c.free_y * GW + c.free_x] = 0;
			if (!in_play(c.start_x, c.start_y) || !in_play(c.goal_x, c.goal_y))
				return r;
			for (int i = 0; i < CELLS; i++) begin
				learned[i] = 0;
				cost[i] = 16'hFFFF;
				fest[i] = 32'hFFFF_FFFF;
				parent[i] = MOVE_NONE;
			end
			s = c.start_y * GW + c.start_x;
			g = c.goal_y * GW + c.goal_x;
			cost[s] = 0;
			fest[s] = dist_q8(c.start_x, c.start_y, c.goal_x, c.goal_y);
			open[0] = 10'(s);
			open_n = 1;
			cur = s;
			while (open_n > 0 && cur != g) begin
				cur = open[0];
				learned[cur] = 1;
				cx = cur % GW;
				cy = cur / GW;
				for (int k = 0; k < 4; k++) begin
					if (k == 0) begin
						if (cy <= PLAY_Y0) continue;
						nb = cur - GW; mv = MOVE_YM;
					end else if (k == 1) begin
						if (cy + 1 >= GH) continue;
						nb = cur + GW; mv = MOVE_YP;
					end else if (k == 2) begin
						if (cx <= 1) continue;
						nb = cur - 1; mv = MOVE_XM;
					end else begin
						if (cx + 1 >= GW) continue;
						nb = cur + 1; mv = MOVE_XP;
					end
					if (!learned[nb] && !blocked[nb] && open_n < ODEP) begin
						open[open_n] = 10'(nb);
						open_n++;
					end
					cand = cost[cur] + 1;
					if (cand < cost[nb]) begin
						nx = nb % GW;
						ny = nb / GW;
						parent[nb] = mv;
						cost[nb] = cand[15:0];
						fest[nb] = cand * 256 + dist_q8(nx, ny, c.goal_x, c.goal_y);
					end
				end
				// Stable insertion sort on the estimate, then drop heads already learned.
				for (int i = 1; i < open_n; i++) begin
					e = open[i];
					j = i;
					while (j > 0 && fest[open[j-1]] > fest[e]) begin
						open[j] = open[j-1];
						j--;
					end
					open[j] = e;
				end
				p = 0;
				while (p < open_n && learned[open[p]])
					p++;
				if (p > 0) begin
					for (int i = 0; i < open_n - p; i++)
						open[i] = open[i+p];
					open_n -= p;
				end
				if (open_n == 0)
					break;
			end
			cur = g;
			for (walk = 0; walk < CELLS; walk++) begin
				if (parent[cur] == MOVE_NONE)
					break;
				case (parent[cur])
					MOVE_YP: par = cur - GW;
					MOVE_XM: par = cur + 1;
					MOVE_XP: par = cur - 1;
					default: par = cur + GW;
				endcase
				if (par < 0 || par >= CELLS)
					break;
				if (par == s) begin
					r.direction = parent[cur][1:0];
					r.found = 1;
					return r;
				end
				cur = par;
			end
			return r;
		endfunction

		function void note_cmd(cmd_t c);
			res_t r;
			r = search_move(c);
			if (r.found)
				n_found++;
			else
				n_missing++;
			due_mem[due_wr[7:0]] = r;
			due_wr++;
		endfunction

		function void check_res(res_t got);
			res_t want;
			if (pending() == 0) begin
				$error("result beat with no command outstanding: direction %0d found %0d",
					got.direction, got.found);
				errors++;
				return;
			end
			want = due_mem[due_rd[7:0]];
			due_rd++;
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				errors++;
			end
			if (got.direction !== want.direction) begin
				$error("direction: expected %0d, got %0d", want.direction, got.direction);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	move_scoreboard sb;
	int cmd_count;
	int res_count;
	bit hold_done;

	grid_astar_next_move dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Offer one command and hold it until the engine takes it. The engine's stall is read
	// right after the edge, which still shows the value from before the edge.
	task automatic offer_cmd(input cmd_t c);
		cmd <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
		sb.note_cmd(c);
		cmd_count++;
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			cmd_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Pause the sender until every predicted move has come back.
	task automatic drain_results();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic cmd_t mk_cmd(int bx, int by, int fx, int fy, int sx, int sy,
		int gx, int gy);
		cmd_t c;
		c.block_x = 5'(bx); c.block_y = 5'(by);
		c.free_x = 5'(fx);  c.free_y = 5'(fy);
		c.start_x = 5'(sx); c.start_y = 5'(sy);
		c.goal_x = 5'(gx);  c.goal_y = 5'(gy);
		return c;
	endfunction

	// Most random commands are well-formed searches between nearby cells in the play area,
	// with obstacles dropped near the start so that detours come up. The rest are noise.
	function automatic cmd_t random_cmd();
		cmd_t c;
		int sx, sy, gx, gy;
		c = cmd_t'(40'({$urandom, $urandom}));
		if ($urandom_range(9) == 0)
			return c;
		sx = $urandom_range(31, 1);
		sy = $urandom_range(31, PLAY_Y0);
		if ($urandom_range(4) == 0) begin
			gx = $urandom_range(31, 1);
			gy = $urandom_range(31, PLAY_Y0);
		end else begin
			gx = sx + $urandom_range(12) - 6;
			gy = sy + $urandom_range(12) - 6;
			gx = (gx < 1) ? 1 : (gx > 31) ? 31 : gx;
			gy = (gy < PLAY_Y0) ? PLAY_Y0 : (gy > 31) ? 31 : gy;
		end
		c.start_x = 5'(sx); c.start_y = 5'(sy);
		c.goal_x = 5'(gx);  c.goal_y = 5'(gy);
		if ($urandom_range(2) == 0) begin
			c.block_x = 5'((sx + $urandom_range(4)) % 32);
			c.block_y = 5'((sy + $urandom_range(4)) % 32);
		end
		if ($urandom_range(19) == 0) begin
			c.block_x = 5'(sx);
			c.block_y = 5'(sy);
		end
		return c;
	endfunction

	// Command side: directed cases, a drain, then random commands in bursts, drained halfway.
	initial begin
		cmd_t dir_q[19];
		int burst;
		sb = new();
		cmd_count = 0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Open grid, two opposite corners of the play area and a plain move each way.
		dir_q[0] = mk_cmd(0, 0, 0, 0, 1, 3, 31, 31);
		dir_q[1] = mk_cmd(0, 0, 0, 0, 31, 31, 1, 3);
		dir_q[2] = mk_cmd(0, 0, 0, 0, 5, 5, 5, 6);
		dir_q[3] = mk_cmd(0, 0, 0, 0, 5, 5, 4, 5);
		dir_q[4] = mk_cmd(0, 0, 0, 0, 5, 5, 6, 5);
		dir_q[5] = mk_cmd(0, 0, 0, 0, 5, 5, 5, 4);
		// Start or goal outside the play area: column 0 and the rows below the third.
		dir_q[6] = mk_cmd(31, 31, 31, 31, 0, 10, 5, 5);
		dir_q[7] = mk_cmd(31, 31, 31, 31, 5, 2, 5, 5);
		dir_q[8] = mk_cmd(31, 31, 31, 31, 5, 5, 5, 0);
		// Start equal to the goal.
		dir_q[9] = mk_cmd(31, 31, 31, 31, 20, 20, 20, 20);
		// The same cell blocked and freed stays free; a blocked start still searches.
		dir_q[10] = mk_cmd(7, 7, 7, 7, 7, 6, 7, 8);
		dir_q[11] = mk_cmd(7, 7, 0, 0, 7, 7, 9, 7);
		// A blocked goal can still be reported found.
		dir_q[12] = mk_cmd(12, 12, 0, 0, 12, 10, 12, 12);
		// Wall in the goal at (20, 10) one side at a time; the last search finds nothing.
		dir_q[13] = mk_cmd(20, 9, 0, 0, 18, 10, 20, 10);
		dir_q[14] = mk_cmd(20, 11, 0, 0, 18, 10, 20, 10);
		dir_q[15] = mk_cmd(19, 10, 0, 0, 18, 10, 20, 10);
		dir_q[16] = mk_cmd(21, 10, 0, 0, 18, 10, 20, 10);
		// A detour around a blocked cell, then freeing it again.
		dir_q[17] = mk_cmd(10, 16, 0, 0, 10, 15, 10, 17);
		dir_q[18] = mk_cmd(31, 0, 10, 16, 10, 15, 10, 17);
		foreach (dir_q[i])
			offer_cmd(dir_q[i]);
		drain_results();

		burst = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2)
				drain_results();
			if (burst == 0) begin
				burst = $urandom_range(8, 1);
				idle_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(40));
			end
			burst--;
			offer_cmd(random_cmd());
		end
		cmd_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Ran %0d commands: %0d with a path found, %0d without.",
			cmd_count, sb.n_found, sb.n_missing);
		$display("Covered play-area edges, blocked starts and goals, a walled goal, ",
			"and result back-pressure.");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Result side: a stall pattern whose mode changes at random, with one long
	// hold-off once enough commands have gone in, so that the engine backs up.
	initial begin
		int mode;
		res_stall <= 1'b0;
		res_count = 0;
		hold_done = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				sb.check_res(res);
				res_count++;
			end
			if (!hold_done && cmd_count >= 30) begin
				hold_done = 1;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
			end else begin
				if ($urandom_range(299) == 0)
					mode = $urandom_range(2);
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(3) == 0);
					default: res_stall <= ($urandom_range(3) != 0);
				endcase
			end
		end
	end

	// The watchdog ends the run when no beat of either kind moves for too long.
	initial begin
		int idle, last_cmd, last_res;
		idle = 0;
		last_cmd = 0;
		last_res = 0;
		forever begin
			@(posedge clk);
			if (cmd_count != last_cmd || res_count != last_res) begin
				idle = 0;
				last_cmd = cmd_count;
				last_res = res_count;
			end else begin
				idle++;
			end
			if (idle >= IDLE_LIMIT) begin
				$display("Timed out with %0d results outstanding.", sb.pending());
				$display("FAIL");
				$finish;
			end
		end
	end

endmodule
